// ----- hdl/hsm_pkg.sv -----
// Package for the hotkey sequence matcher: field widths, command and register codes,
// the controller state type and the command and status structs.
// Depends on nothing; used by every module of the block.
`default_nettype none
package hsm_pkg;
    localparam int KEY_W   = 10;
    localparam int ST_W    = 2;
    localparam int EV_W    = KEY_W + ST_W;
    localparam int LEN_W   = 5;
    localparam int STEP_W  = 5;
    localparam int FIRE_W  = 4;
    localparam int SIDX_W  = 4;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_KEY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PAT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LEN = 2'd2;

    localparam logic [ST_W-1:0] ST_RELEASE = 2'd0;
    localparam logic [ST_W-1:0] ST_PRESS   = 2'd1;

    localparam logic REG_TRIGGER = 1'b0;
    localparam logic REG_ESCAPE  = 1'b1;

    localparam logic [KEY_W-1:0] TRIGGER_RESET = 10'd100;
    localparam logic [KEY_W-1:0] ESCAPE_RESET  = 10'd1;
    localparam logic [STEP_W-1:0] STEP_MAX     = 5'd31;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_RP_OUTER, S_RP_INNER, S_TRIG,
        S_M_SEQ, S_M_RD, S_M_CMP, S_M_FIN, S_EMIT, S_FINAL
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic m_start;
        logic rp_clear;
        logic rp_outer_step;
        logic rp_load_j;
        logic rp_inner_step;
        logic rp_inner_end;
        logic tr_check;
        logic m_skip;
        logic m_seq_begin;
        logic m_seq_end;
        logic m_cmp;
        logic m_finish;
        logic s_next;
        logic out_fire;
        logic out_final;
    } cmd_t;

    typedef struct packed {
        logic is_event;
        logic menu_on;
        logic j_done;
        logic j_rel;
        logic rp_i_done;
        logic m_i_done;
        logic s_done;
        logic seq_imposs;
        logic fire_here;
        logic out_free;
    } status_t;
endpackage
`default_nettype wire

// ----- hdl/hotkey_sequence_matcher.sv -----
// Top level of the hotkey sequence matcher: stream ports, register port and wiring
// of the controller (hsm_ctrl) and datapath (hsm_datapath). Uses hsm_pkg.
//
// The block takes one transaction at a time. A pattern or length write passes through the
// IDLE, EXEC and FINAL states. A key event with the menu closed replays the history to
// check that all keys are released. With the menu open it instead walks the sequences
// through the pattern memory, comparing stored events with pattern steps, then steps
// through the sequences to report fired indexes.
// Each fired sequence gives one result transaction, followed by a final one with tlast set.
`default_nettype none
module hotkey_sequence_matcher #(
    parameter int WINDOW    = 30,
    parameter int MAX_SEQ   = 16,
    parameter int MAX_LEN   = 16,
    parameter int KEY_CODES = 768
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: command[1:0], key_code[11:2], key_state[13:12],
    // seq_index[17:14], step_index[21:18], seq_length[26:22], zero fill.
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: fire[0], fire_index[4:1], consume[5], menu_active[6], zero fill.
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    hsm_pkg::cmd_t    cmd;
    hsm_pkg::status_t status;
    logic [hsm_pkg::KEY_W-1:0]  trigger_key, escape_key;
    logic                       fire, consume, menu_active;
    logic [hsm_pkg::FIRE_W-1:0] fire_index;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == hsm_pkg::REG_ESCAPE) ? {22'b0, escape_key}
                                                     : {22'b0, trigger_key};

    hsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hsm_datapath #(
        .WINDOW    (WINDOW),
        .MAX_SEQ   (MAX_SEQ),
        .MAX_LEN   (MAX_LEN),
        .KEY_CODES (KEY_CODES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_command      (s_tdata[1:0]),
        .in_key_code     (s_tdata[11:2]),
        .in_key_state    (s_tdata[13:12]),
        .in_seq_index    (s_tdata[17:14]),
        .in_step_index   (s_tdata[21:18]),
        .in_seq_length   (s_tdata[26:22]),
        .cfg_we          (psel && penable && pwrite),
        .cfg_sel         (paddr[2]),
        .cfg_wdata       (pwdata[9:0]),
        .trigger_key     (trigger_key),
        .escape_key      (escape_key),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_fire        (fire),
        .out_fire_index  (fire_index),
        .out_consume     (consume),
        .out_menu_active (menu_active),
        .out_last        (m_tlast)
    );

    assign m_tdata = {1'b0, menu_active, consume, fire_index, fire};
endmodule
`default_nettype wire

// ----- hdl/hsm_ctrl.sv -----
// Controller state machine of the hotkey sequence matcher.
// Depends on hsm_pkg; drives the datapath through command and status structs.
`default_nettype none
module hsm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  hsm_pkg::status_t    status,
    output hsm_pkg::cmd_t       cmd
);
    hsm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hsm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            hsm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = hsm_pkg::S_EXEC;
                end
            end
            hsm_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (!status.is_event)
                begin
                    state_next = hsm_pkg::S_FINAL;
                end
                else if (status.menu_on)
                begin
                    cmd.m_start = 1'b1;
                    state_next = hsm_pkg::S_M_SEQ;
                end
                else
                begin
                    cmd.rp_clear = 1'b1;
                    state_next = hsm_pkg::S_RP_OUTER;
                end
            end
            hsm_pkg::S_RP_OUTER:
            begin
                priority if (status.j_done)
                begin
                    state_next = hsm_pkg::S_TRIG;
                end
                else if (status.j_rel)
                begin
                    cmd.rp_load_j = 1'b1;
                    state_next = hsm_pkg::S_RP_INNER;
                end
                else
                begin
                    cmd.rp_outer_step = 1'b1;
                end
            end
            hsm_pkg::S_RP_INNER:
            begin
                if (status.rp_i_done)
                begin
                    cmd.rp_inner_end = 1'b1;
                    state_next = hsm_pkg::S_RP_OUTER;
                end
                else
                begin
                    cmd.rp_inner_step = 1'b1;
                end
            end
            hsm_pkg::S_TRIG:
            begin
                cmd.tr_check = 1'b1;
                state_next = hsm_pkg::S_FINAL;
            end
            hsm_pkg::S_M_SEQ:
            begin
                priority if (status.s_done)
                begin
                    state_next = hsm_pkg::S_M_FIN;
                end
                else if (status.seq_imposs)
                begin
                    cmd.m_skip = 1'b1;
                end
                else
                begin
                    cmd.m_seq_begin = 1'b1;
                    state_next = hsm_pkg::S_M_RD;
                end
            end
            hsm_pkg::S_M_RD:
            begin
                if (status.m_i_done)
                begin
                    cmd.m_seq_end = 1'b1;
                    state_next = hsm_pkg::S_M_SEQ;
                end
                else
                begin
                    state_next = hsm_pkg::S_M_CMP;
                end
            end
            hsm_pkg::S_M_CMP:
            begin
                cmd.m_cmp = 1'b1;
                state_next = hsm_pkg::S_M_RD;
            end
            hsm_pkg::S_M_FIN:
            begin
                cmd.m_finish = 1'b1;
                state_next = hsm_pkg::S_EMIT;
            end
            hsm_pkg::S_EMIT:
            begin
                priority if (status.s_done)
                begin
                    state_next = hsm_pkg::S_FINAL;
                end
                else if (!status.fire_here)
                begin
                    cmd.s_next = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.out_fire = 1'b1;
                    cmd.s_next = 1'b1;
                end
                else
                begin
                    cmd.s_next = 1'b0;
                end
            end
            hsm_pkg::S_FINAL:
            begin
                if (status.out_free)
                begin
                    cmd.out_final = 1'b1;
                    state_next = hsm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hsm_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- hdl/hsm_datapath.sv -----
// Datapath of the hotkey sequence matcher: event history, balance replay counters,
// pattern memory, sequence lengths, match counters and the output register. Uses hsm_pkg.
`default_nettype none
module hsm_datapath #(
    parameter int WINDOW    = 30,
    parameter int MAX_SEQ   = 16,
    parameter int MAX_LEN   = 16,
    parameter int KEY_CODES = 768
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  hsm_pkg::cmd_t                    cmd,
    output hsm_pkg::status_t                 status,
    input  wire logic [hsm_pkg::CMD_W-1:0]   in_command,
    input  wire logic [hsm_pkg::KEY_W-1:0]   in_key_code,
    input  wire logic [hsm_pkg::ST_W-1:0]    in_key_state,
    input  wire logic [hsm_pkg::SIDX_W-1:0]  in_seq_index,
    input  wire logic [hsm_pkg::SIDX_W-1:0]  in_step_index,
    input  wire logic [hsm_pkg::LEN_W-1:0]   in_seq_length,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_sel,
    input  wire logic [hsm_pkg::KEY_W-1:0]   cfg_wdata,
    output logic [hsm_pkg::KEY_W-1:0]        trigger_key,
    output logic [hsm_pkg::KEY_W-1:0]        escape_key,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             out_fire,
    output logic [hsm_pkg::FIRE_W-1:0]       out_fire_index,
    output logic                             out_consume,
    output logic                             out_menu_active,
    output logic                             out_last
);
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int HW  = $clog2(WINDOW);
    localparam int IW  = (CW > hsm_pkg::STEP_W) ? CW : hsm_pkg::STEP_W;
    localparam int SW  = $clog2(MAX_SEQ + 1);
    localparam int SIW = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
    localparam int DEPTH = MAX_SEQ * MAX_LEN;
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [hsm_pkg::EV_W-1:0]   hist_reg [WINDOW];
    logic [CW-1:0]              fill_reg;
    logic [IW-1:0]              j_reg, i_reg;
    logic [CW-1:0]              cnt_reg, open_reg;
    logic [hsm_pkg::KEY_W-1:0]  jkey_reg;
    logic [SW-1:0]              s_reg;
    logic                       poss_reg, any_reg, fired_reg;
    logic [MAX_SEQ-1:0]         fire_reg;
    logic [hsm_pkg::CMD_W-1:0]  cmd_reg;
    logic [hsm_pkg::KEY_W-1:0]  key_reg;
    logic [hsm_pkg::ST_W-1:0]   st_reg;
    logic [hsm_pkg::SIDX_W-1:0] si_reg, pi_reg;
    logic [hsm_pkg::LEN_W-1:0]  slen_reg;
    logic                       menu_reg, consume_reg;
    logic [hsm_pkg::STEP_W-1:0] steps_reg;
    logic [hsm_pkg::EV_W-1:0]   prev_ev_reg, cur_ev_reg;
    logic [hsm_pkg::KEY_W-1:0]  trig_reg, esc_reg;
    logic [hsm_pkg::LEN_W-1:0]  len_reg [MAX_SEQ];
    logic [hsm_pkg::EV_W-1:0]   pat_mem [DEPTH];
    logic [hsm_pkg::EV_W-1:0]   pat_rd_reg, hist_rd_reg;
    logic                       out_valid_reg, out_fire_reg, out_cons_reg;
    logic                       out_menu_reg, out_last_reg;
    logic [hsm_pkg::FIRE_W-1:0] out_idx_reg;

    logic [SIW-1:0]             s_idx;
    logic [hsm_pkg::EV_W-1:0]   ev_new, hist_j, hist_i;
    logic [hsm_pkg::KEY_W-1:0]  hi_key, hj_key;
    logic [hsm_pkg::ST_W-1:0]   hi_st, hj_st;
    logic                       hj_valid;
    logic [hsm_pkg::LEN_W-1:0]  cur_len;
    logic [IW:0]                base_sum;
    logic [AW-1:0]              rd_addr, wr_addr;
    logic                       out_free;

    assign s_idx    = s_reg[SIW-1:0];
    assign ev_new   = {key_reg, st_reg};
    assign hist_j   = hist_reg[j_reg[HW-1:0]];
    assign hist_i   = hist_reg[i_reg[HW-1:0]];
    assign hj_key   = hist_j[hsm_pkg::EV_W-1:hsm_pkg::ST_W];
    assign hj_st    = hist_j[hsm_pkg::ST_W-1:0];
    assign hi_key   = hist_i[hsm_pkg::EV_W-1:hsm_pkg::ST_W];
    assign hi_st    = hist_i[hsm_pkg::ST_W-1:0];
    assign hj_valid = int'(hj_key) < KEY_CODES;
    assign cur_len  = len_reg[s_idx];
    assign base_sum = (IW + 1)'(fill_reg) - (IW + 1)'(steps_reg) + (IW + 1)'(i_reg);
    assign rd_addr  = AW'(int'(s_idx) * MAX_LEN + int'(i_reg));
    assign wr_addr  = AW'(int'(si_reg) * MAX_LEN + int'(pi_reg));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        status.is_event   = cmd_reg == hsm_pkg::CMD_KEY;
        status.menu_on    = menu_reg;
        status.j_done     = j_reg == IW'(fill_reg);
        status.j_rel      = hj_valid && hj_st == hsm_pkg::ST_RELEASE;
        status.rp_i_done  = i_reg == j_reg;
        status.m_i_done   = i_reg == IW'(steps_reg);
        status.s_done     = s_reg == SW'(MAX_SEQ);
        status.seq_imposs = (steps_reg > hsm_pkg::STEP_W'(cur_len))
                         || (IW'(steps_reg) > IW'(fill_reg));
        status.fire_here  = fire_reg[s_idx];
        status.out_free   = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && cmd_reg == hsm_pkg::CMD_PAT
            && int'(si_reg) < MAX_SEQ && int'(pi_reg) < MAX_LEN)
        begin
            pat_mem[wr_addr] <= ev_new;
        end
        pat_rd_reg  <= pat_mem[rd_addr];
        hist_rd_reg <= hist_reg[base_sum[HW-1:0]];
        if (cmd.exec && cmd_reg == hsm_pkg::CMD_KEY)
        begin
            if (fill_reg < CW'(WINDOW))
            begin
                hist_reg[fill_reg[HW-1:0]] <= ev_new;
            end
            else
            begin
                for (int k = 0; k < WINDOW - 1; k++)
                begin
                    hist_reg[k] <= hist_reg[k + 1];
                end
                hist_reg[WINDOW - 1] <= ev_new;
            end
        end
        if (cmd.load)
        begin
            cmd_reg  <= in_command;
            key_reg  <= in_key_code;
            st_reg   <= in_key_state;
            si_reg   <= in_seq_index;
            pi_reg   <= in_step_index;
            slen_reg <= in_seq_length;
        end
        if (cmd.rp_load_j)
        begin
            jkey_reg <= hj_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            j_reg         <= '0;
            i_reg         <= '0;
            cnt_reg       <= '0;
            open_reg      <= '0;
            s_reg         <= '0;
            poss_reg      <= 1'b0;
            any_reg       <= 1'b0;
            fired_reg     <= 1'b0;
            fire_reg      <= '0;
            menu_reg      <= 1'b0;
            consume_reg   <= 1'b0;
            steps_reg     <= '0;
            prev_ev_reg   <= '0;
            cur_ev_reg    <= '0;
            trig_reg      <= hsm_pkg::TRIGGER_RESET;
            esc_reg       <= hsm_pkg::ESCAPE_RESET;
            out_valid_reg <= 1'b0;
            out_fire_reg  <= 1'b0;
            out_idx_reg   <= '0;
            out_cons_reg  <= 1'b0;
            out_menu_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
            for (int k = 0; k < MAX_SEQ; k++)
            begin
                len_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_sel == hsm_pkg::REG_TRIGGER)
                begin
                    trig_reg <= cfg_wdata;
                end
                else
                begin
                    esc_reg <= cfg_wdata;
                end
            end
            if (cmd.exec)
            begin
                consume_reg <= cmd_reg == hsm_pkg::CMD_KEY && menu_reg && key_reg != esc_reg;
                if (cmd_reg == hsm_pkg::CMD_LEN && int'(si_reg) < MAX_SEQ)
                begin
                    len_reg[si_reg[SIW-1:0]] <= (int'(slen_reg) > MAX_LEN)
                                              ? hsm_pkg::LEN_W'(MAX_LEN) : slen_reg;
                end
                if (cmd_reg == hsm_pkg::CMD_KEY)
                begin
                    prev_ev_reg <= cur_ev_reg;
                    cur_ev_reg  <= ev_new;
                    if (fill_reg < CW'(WINDOW))
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
            end
            if (cmd.m_start)
            begin
                s_reg     <= '0;
                any_reg   <= 1'b0;
                fired_reg <= 1'b0;
                fire_reg  <= '0;
                if (steps_reg != hsm_pkg::STEP_MAX)
                begin
                    steps_reg <= steps_reg + 1'b1;
                end
            end
            if (cmd.rp_clear)
            begin
                j_reg    <= '0;
                open_reg <= '0;
            end
            if (cmd.rp_outer_step)
            begin
                j_reg <= j_reg + 1'b1;
                if (hj_valid && hj_st == hsm_pkg::ST_PRESS)
                begin
                    open_reg <= open_reg + 1'b1;
                end
            end
            if (cmd.rp_load_j)
            begin
                i_reg   <= '0;
                cnt_reg <= '0;
            end
            if (cmd.rp_inner_step)
            begin
                i_reg <= i_reg + 1'b1;
                if (hi_key == jkey_reg)
                begin
                    if (hi_st == hsm_pkg::ST_PRESS)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else if (hi_st == hsm_pkg::ST_RELEASE && cnt_reg != '0)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
            end
            if (cmd.rp_inner_end)
            begin
                j_reg <= j_reg + 1'b1;
                if (cnt_reg != '0)
                begin
                    open_reg <= open_reg - 1'b1;
                end
            end
            if (cmd.tr_check)
            begin
                if (fill_reg >= CW'(2) && open_reg == '0
                    && prev_ev_reg == {trig_reg, hsm_pkg::ST_PRESS}
                    && cur_ev_reg == {trig_reg, hsm_pkg::ST_RELEASE})
                begin
                    menu_reg  <= 1'b1;
                    steps_reg <= '0;
                end
            end
            if (cmd.m_skip || cmd.s_next)
            begin
                s_reg <= s_reg + 1'b1;
            end
            if (cmd.m_seq_begin)
            begin
                i_reg    <= '0;
                poss_reg <= 1'b1;
            end
            if (cmd.m_cmp)
            begin
                i_reg <= i_reg + 1'b1;
                if (hist_rd_reg != pat_rd_reg)
                begin
                    poss_reg <= 1'b0;
                end
            end
            if (cmd.m_seq_end)
            begin
                s_reg <= s_reg + 1'b1;
                if (poss_reg)
                begin
                    any_reg <= 1'b1;
                    if (hsm_pkg::STEP_W'(cur_len) == steps_reg)
                    begin
                        fire_reg[s_idx] <= 1'b1;
                        fired_reg       <= 1'b1;
                    end
                end
            end
            if (cmd.m_finish)
            begin
                s_reg <= '0;
                if (!any_reg || fired_reg)
                begin
                    fill_reg <= '0;
                    menu_reg <= 1'b0;
                end
            end
            if (cmd.out_fire || cmd.out_final)
            begin
                out_valid_reg <= 1'b1;
                out_fire_reg  <= cmd.out_fire;
                out_idx_reg   <= cmd.out_fire ? hsm_pkg::FIRE_W'(s_reg) : '0;
                out_cons_reg  <= consume_reg;
                out_menu_reg  <= menu_reg;
                out_last_reg  <= cmd.out_final;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign trigger_key     = trig_reg;
    assign escape_key      = esc_reg;
    assign out_valid       = out_valid_reg;
    assign out_fire        = out_fire_reg;
    assign out_fire_index  = out_idx_reg;
    assign out_consume     = out_cons_reg;
    assign out_menu_active = out_menu_reg;
    assign out_last        = out_last_reg;
endmodule
`default_nettype wire
